### hdl/sphcv_pkg.sv
package sphcv_pkg;

    localparam int MAX_BANDS = 128;

    localparam int LAT_W   = 7;
    localparam int LON_W   = 9;
    localparam int IDX_W   = 10;
    localparam int RAD_W   = 16;
    localparam int STEP_W  = 23;
    localparam int COORD_W = 17;
    localparam int MAG_W   = 17;

    localparam logic [STEP_W-1:0] STEP_MIN   = 23'd58982;
    localparam logic [STEP_W-1:0] STEP_MAX   = 23'd5898240;
    localparam logic [RAD_W-1:0]  RADIUS_RST = 16'd256;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP = 2'd1;

    // horner chain: each divisor split into a power of two and an odd part
    localparam int NUM_CELLS = 6;
    localparam int DIV_SHIFT = 37;
    localparam int MAGIC_W   = 38;
    localparam int unsigned SIN_POW2 [NUM_CELLS] = '{2, 1, 3, 1, 2, 1};
    localparam int unsigned SIN_ODD  [NUM_CELLS] = '{39, 55, 9, 21, 5, 3};
    localparam int unsigned COS_POW2 [NUM_CELLS] = '{2, 1, 3, 1, 2, 1};
    localparam int unsigned COS_ODD  [NUM_CELLS] = '{33, 45, 7, 15, 3, 1};

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // corner selection per vertex, bit k for vertex k
    localparam logic [5:0] USE_PHI1 = 6'b101100;
    localparam logic [5:0] USE_TH1  = 6'b110010;

    typedef enum logic [1:0] {
        TAG_PHI0 = 2'd0,
        TAG_PHI1 = 2'd1,
        TAG_TH0  = 2'd2,
        TAG_TH1  = 2'd3
    } tag_t;

    typedef struct packed {
        tag_t        tag;
        logic        lower;
        logic [1:0]  quad;
        logic [30:0] x;
        logic [31:0] x2;
    } carry_t;

    typedef struct packed {
        carry_t      c;
        logic [30:0] ts;
        logic [30:0] tc;
    } trig_t;

    typedef struct packed {
        logic [MAG_W-1:0] smag;
        logic             sneg;
        logic [MAG_W-1:0] cmag;
        logic             cneg;
    } corner_t;

endpackage

### hdl/sphcv_front.sv
module sphcv_front
    import sphcv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  tag_t              in_tag,
    input  logic              in_lower,
    input  logic [IDX_W-1:0]  in_index,
    input  logic [STEP_W-1:0] in_step,
    output logic              out_valid,
    output trig_t             out_trig
);

    localparam logic [13:0] RECIP45   = 14'd11651;
    localparam logic [26:0] DEG2RAD   = 27'd74961321;
    localparam logic [49:0] X_ROUND   = 50'd131072;

    typedef struct packed {
        tag_t tag;
        logic lower;
    } fctl_t;

    logic [5:0]  vld_reg;
    fctl_t       ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg, ctl6_reg;
    logic [31:0] ang_reg;
    logic [26:0] red_reg;
    logic [12:0] n_reg;
    logic [18:0] low19_reg;
    logic [7:0]  v_reg;
    logic [16:0] low17_reg;
    logic [22:0] r_reg;
    logic [1:0]  quad4_reg, quad5_reg, quad6_reg;
    logic [30:0] x_reg, x6_reg;
    logic [61:0] xx_reg;

    logic [7:0]  qq;
    logic [12:0] rem13;
    logic [1:0]  quad_next;
    logic [7:0]  rr_next;

    always_comb
    begin
        qq    = red_reg[26:19];
        rem13 = n_reg - 13'(qq) * 13'd45;
    end

    always_comb
    begin
        priority if (v_reg >= 8'd135)
        begin
            quad_next = 2'd3;
            rr_next   = v_reg - 8'd135;
        end
        else if (v_reg >= 8'd90)
        begin
            quad_next = 2'd2;
            rr_next   = v_reg - 8'd90;
        end
        else if (v_reg >= 8'd45)
        begin
            quad_next = 2'd1;
            rr_next   = v_reg - 8'd45;
        end
        else
        begin
            quad_next = 2'd0;
            rr_next   = v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        // angle in q16 degrees
        ctl1_reg  <= '{tag: in_tag, lower: in_lower};
        ang_reg   <= 32'(in_index) * 32'(in_step);
        // whole turns: top bits over 45 by reciprocal
        ctl2_reg  <= ctl1_reg;
        n_reg     <= ang_reg[31:19];
        red_reg   <= 27'(ang_reg[31:19]) * 27'(RECIP45);
        low19_reg <= ang_reg[18:0];
        ctl3_reg  <= ctl2_reg;
        v_reg     <= {rem13[5:0], low19_reg[18:17]};
        low17_reg <= low19_reg[16:0];
        // quadrant and remainder
        ctl4_reg  <= ctl3_reg;
        quad4_reg <= quad_next;
        r_reg     <= {rr_next[5:0], low17_reg};
        // radians in q30
        ctl5_reg  <= ctl4_reg;
        quad5_reg <= quad4_reg;
        x_reg     <= 31'((50'(r_reg) * 50'(DEG2RAD) + X_ROUND) >> 18);
        ctl6_reg  <= ctl5_reg;
        quad6_reg <= quad5_reg;
        x6_reg    <= x_reg;
        xx_reg    <= 62'(x_reg) * 62'(x_reg);
    end

    assign out_valid       = vld_reg[5];
    assign out_trig.c.tag   = ctl6_reg.tag;
    assign out_trig.c.lower = ctl6_reg.lower;
    assign out_trig.c.quad  = quad6_reg;
    assign out_trig.c.x     = x6_reg;
    assign out_trig.c.x2    = xx_reg[61:30];
    assign out_trig.ts      = ONE_Q30;
    assign out_trig.tc      = ONE_Q30;

endmodule

### hdl/sphcv_cell.sv
module sphcv_cell
    import sphcv_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  trig_t in_trig,
    output logic  out_valid,
    output trig_t out_trig
);

    localparam logic [MAGIC_W-1:0] S_MAGIC = MAGIC_W'(((64'd1 << DIV_SHIFT)
        + 64'(SIN_ODD[STAGE]) - 64'd1) / 64'(SIN_ODD[STAGE]));
    localparam logic [MAGIC_W-1:0] C_MAGIC = MAGIC_W'(((64'd1 << DIV_SHIFT)
        + 64'(COS_ODD[STAGE]) - 64'd1) / 64'(COS_ODD[STAGE]));

    logic [2:0]  vld_reg;
    carry_t      ca_reg, cb_reg;
    logic [31:0] ps_reg, pc_reg;
    logic [67:0] qs_reg, qc_reg;
    trig_t       out_reg;
    logic [31:0] ns, nc;
    logic [30:0] qs, qc;
    logic [30:0] ts_next, tc_next;

    always_comb
    begin
        ns      = ps_reg >> SIN_POW2[STAGE];
        nc      = pc_reg >> COS_POW2[STAGE];
        qs      = qs_reg[67:DIV_SHIFT];
        qc      = qc_reg[67:DIV_SHIFT];
        // a term that would go negative saturates at zero
        ts_next = (qs >= ONE_Q30) ? '0 : ONE_Q30 - qs;
        tc_next = (qc >= ONE_Q30) ? '0 : ONE_Q30 - qc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        ca_reg     <= in_trig.c;
        ps_reg     <= 32'((63'(in_trig.c.x2) * 63'(in_trig.ts)) >> 30);
        pc_reg     <= 32'((63'(in_trig.c.x2) * 63'(in_trig.tc)) >> 30);
        cb_reg     <= ca_reg;
        qs_reg     <= 68'(ns) * 68'(S_MAGIC);
        qc_reg     <= 68'(nc) * 68'(C_MAGIC);
        out_reg.c  <= cb_reg;
        out_reg.ts <= ts_next;
        out_reg.tc <= tc_next;
    end

    assign out_valid = vld_reg[2];
    assign out_trig  = out_reg;

endmodule

### hdl/sphcv_vertex.sv
module sphcv_vertex
    import sphcv_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  trig_t                     in_trig,
    input  logic [RAD_W-1:0]          radius,
    output logic                      vertex_valid,
    output logic signed [COORD_W-1:0] vx,
    output logic signed [COORD_W-1:0] vy,
    output logic signed [COORD_W-1:0] vz,
    output logic                      last_vertex
);

    logic        p1_vld_reg, p2_vld_reg;
    carry_t      p1_c_reg;
    logic [30:0] p1_s_reg, p1_c_tc_reg;
    tag_t        p2_tag_reg;
    logic        p2_lower_reg;
    corner_t     p2_ent_reg;
    corner_t     stage_reg [0:2];
    corner_t     hold_reg [0:3];
    logic        hold_lower_reg;
    logic        vact_reg;
    logic [2:0]  vcnt_reg;
    logic        v1_vld_reg, v2_vld_reg, o_vld_reg;
    logic [32:0] rs_reg, zp1_reg, zp2_reg;
    logic [MAG_W-1:0] pm_s_reg, pm_c_reg;
    logic        xn1_reg, yn1_reg, zn1_reg, last1_reg;
    logic        xn2_reg, yn2_reg, zn2_reg, last2_reg;
    logic [49:0] xp_reg, yp_reg;
    logic signed [COORD_W-1:0] vx_reg, vy_reg, vz_reg;
    logic        last_reg;

    logic [MAG_W-1:0] s16, c16, xm, ym, zm;
    corner_t     ent_next, phi, th;
    logic        start_seq;

    always_comb
    begin
        s16 = MAG_W'((32'(p1_s_reg) + 32'd8192) >> 14);
        c16 = MAG_W'((32'(p1_c_tc_reg) + 32'd8192) >> 14);
        unique case (p1_c_reg.quad)
            2'd0:    ent_next = '{smag: s16, sneg: 1'b0, cmag: c16, cneg: 1'b0};
            2'd1:    ent_next = '{smag: c16, sneg: 1'b0, cmag: s16, cneg: 1'b1};
            2'd2:    ent_next = '{smag: s16, sneg: 1'b1, cmag: c16, cneg: 1'b1};
            default: ent_next = '{smag: c16, sneg: 1'b1, cmag: s16, cneg: 1'b0};
        endcase
    end

    assign start_seq = p2_vld_reg && (p2_tag_reg == TAG_TH1);

    always_comb
    begin
        phi = USE_PHI1[vcnt_reg] ? hold_reg[1] : hold_reg[0];
        th  = USE_TH1[vcnt_reg] ? hold_reg[3] : hold_reg[2];
        xm  = MAG_W'((xp_reg + 50'h0_8000_0000) >> 32);
        ym  = MAG_W'((yp_reg + 50'h0_8000_0000) >> 32);
        zm  = MAG_W'((zp2_reg + 33'd32768) >> 16);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            vact_reg   <= 1'b0;
            vcnt_reg   <= '0;
            v1_vld_reg <= 1'b0;
            v2_vld_reg <= 1'b0;
            o_vld_reg  <= 1'b0;
        end
        else
        begin
            p1_vld_reg <= in_valid;
            p2_vld_reg <= p1_vld_reg;
            v1_vld_reg <= vact_reg;
            v2_vld_reg <= v1_vld_reg;
            o_vld_reg  <= v2_vld_reg;
            if (start_seq)
            begin
                vact_reg <= 1'b1;
                vcnt_reg <= '0;
            end
            else if (vact_reg)
            begin
                if (vcnt_reg == 3'd5)
                begin
                    vact_reg <= 1'b0;
                end
                else
                begin
                    vcnt_reg <= vcnt_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p1_c_reg     <= in_trig.c;
        p1_s_reg     <= 31'((62'(in_trig.c.x) * 62'(in_trig.ts)) >> 30);
        p1_c_tc_reg  <= in_trig.tc;
        p2_tag_reg   <= p1_c_reg.tag;
        p2_lower_reg <= p1_c_reg.lower;
        p2_ent_reg   <= ent_next;
        if (p2_vld_reg && (p2_tag_reg != TAG_TH1))
        begin
            stage_reg[p2_tag_reg] <= p2_ent_reg;
        end
        if (start_seq)
        begin
            hold_reg[0]    <= stage_reg[0];
            hold_reg[1]    <= stage_reg[1];
            hold_reg[2]    <= stage_reg[2];
            hold_reg[3]    <= p2_ent_reg;
            hold_lower_reg <= p2_lower_reg;
        end
        rs_reg    <= 33'(radius) * 33'(th.smag);
        zp1_reg   <= 33'(radius) * 33'(th.cmag);
        pm_s_reg  <= phi.smag;
        pm_c_reg  <= phi.cmag;
        xn1_reg   <= phi.sneg ^ th.sneg;
        yn1_reg   <= phi.cneg ^ th.sneg;
        zn1_reg   <= th.cneg ^ hold_lower_reg;
        last1_reg <= (vcnt_reg == 3'd5);
        xp_reg    <= 50'(rs_reg) * 50'(pm_s_reg);
        yp_reg    <= 50'(rs_reg) * 50'(pm_c_reg);
        zp2_reg   <= zp1_reg;
        xn2_reg   <= xn1_reg;
        yn2_reg   <= yn1_reg;
        zn2_reg   <= zn1_reg;
        last2_reg <= last1_reg;
        vx_reg    <= xn2_reg ? -$signed(xm) : $signed(xm);
        vy_reg    <= yn2_reg ? -$signed(ym) : $signed(ym);
        vz_reg    <= zn2_reg ? -$signed(zm) : $signed(zm);
        last_reg  <= last2_reg;
    end

    assign vertex_valid = o_vld_reg;
    assign vx           = vx_reg;
    assign vy           = vy_reg;
    assign vz           = vz_reg;
    assign last_vertex  = last_reg;

endmodule

### hdl/sphere_cell_vertex_generator_unit.sv
// uv sphere cell vertex generator
// a request names one grid cell: lat_index, lon_index and lower_half.
// it is taken at a rising edge where start is high and busy is low.
// for each request the unit emits six vertices (two triangles), one per
// cycle, each shown on vx/vy/vz for one cycle with vertex_valid high;
// the sixth carries last_vertex. the receiver cannot stall the unit.
// the single vertex port sets the request rate: busy stays high after an
// accepted request until the last slot of its issue window, when the
// next request can already be taken. the first vertex is registered
// once the last corner angle (theta1) has issued and passed the angle
// front end, the chain of six horner cells and corner collection and
// radius scaling.
// configuration: cfg_valid/cfg_ready write radius (index 0) or
// angle_step (index 1); cfg_ready is always high, other indexes are
// dropped. write only while idle.
// reset: radius returns to 1.0, angle_step to 90 degrees, all pipeline
// valids clear and no vertex is emitted.
module sphere_cell_vertex_generator_unit
    import sphcv_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [LAT_W-1:0]          lat_index,
    input  logic [LON_W-1:0]          lon_index,
    input  logic                      lower_half,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [STEP_W-1:0]         cfg_data,
    output logic                      vertex_valid,
    output logic signed [COORD_W-1:0] vx,
    output logic signed [COORD_W-1:0] vy,
    output logic signed [COORD_W-1:0] vz,
    output logic                      last_vertex
);

    // configuration registers
    logic [RAD_W-1:0]  radius_reg;
    logic [STEP_W-1:0] angle_step_reg;

    // request capture and angle issue
    logic              active_reg;
    logic [2:0]        cnt_reg;
    logic [LAT_W-1:0]  lat_reg;
    logic [LON_W-1:0]  lon_reg;
    logic              lower_reg;
    logic              accept;
    logic              issue_valid;
    tag_t              issue_tag;
    logic [IDX_W-1:0]  issue_index;
    logic [STEP_W-1:0] step_clamped;
    logic [LAT_W-1:0]  lat_mod [0:(1 << LAT_W)-1];

    // horner cell chain
    logic              chain_vld [0:NUM_CELLS];
    trig_t             chain_trig [0:NUM_CELLS];

    // band index wrap, folded into a constant table
    for (genvar gi = 0; gi < (1 << LAT_W); gi++)
    begin : g_lat_mod
        assign lat_mod[gi] = LAT_W'(gi % MAX_BANDS);
    end

    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    // last slot of the issue window frees the port for the next request
    assign busy      = active_reg && (cnt_reg != 3'd5);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg     <= RADIUS_RST;
            angle_step_reg <= STEP_MAX;
            active_reg     <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_RADIUS:     radius_reg     <= cfg_data[RAD_W-1:0];
                    REG_ANGLE_STEP: angle_step_reg <= cfg_data;
                    default:        ;
                endcase
            end
            if (accept)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
            end
            else if (active_reg)
            begin
                if (cnt_reg == 3'd5)
                begin
                    active_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lat_reg   <= lat_mod[lat_index];
            lon_reg   <= lon_index;
            lower_reg <= lower_half;
        end
    end

    // the four corner angles leave one per cycle: phi0, phi1, theta0, theta1
    always_comb
    begin
        issue_valid = active_reg && (cnt_reg < 3'd4);
        issue_tag   = tag_t'(cnt_reg[1:0]);
        unique case (issue_tag)
            TAG_PHI0: issue_index = IDX_W'(lon_reg);
            TAG_PHI1: issue_index = IDX_W'(lon_reg) + IDX_W'(1);
            TAG_TH0:  issue_index = IDX_W'(lat_reg);
            default:  issue_index = IDX_W'(lat_reg) + IDX_W'(1);
        endcase
        priority if (angle_step_reg < STEP_MIN)
        begin
            step_clamped = STEP_MIN;
        end
        else if (angle_step_reg > STEP_MAX)
        begin
            step_clamped = STEP_MAX;
        end
        else
        begin
            step_clamped = angle_step_reg;
        end
    end

    sphcv_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (issue_valid),
        .in_tag    (issue_tag),
        .in_lower  (lower_reg),
        .in_index  (issue_index),
        .in_step   (step_clamped),
        .out_valid (chain_vld[0]),
        .out_trig  (chain_trig[0])
    );

    // one cell per horner term, sine and cosine side by side
    for (genvar gc = 0; gc < NUM_CELLS; gc++)
    begin : g_cell
        sphcv_cell #(
            .STAGE (gc)
        ) u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_vld[gc]),
            .in_trig   (chain_trig[gc]),
            .out_valid (chain_vld[gc+1]),
            .out_trig  (chain_trig[gc+1])
        );
    end

    // corner collection, vertex ordering and radius scaling
    sphcv_vertex u_vertex
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (chain_vld[NUM_CELLS]),
        .in_trig      (chain_trig[NUM_CELLS]),
        .radius       (radius_reg),
        .vertex_valid (vertex_valid),
        .vx           (vx),
        .vy           (vy),
        .vz           (vz),
        .last_vertex  (last_vertex)
    );

endmodule
